// File: design/a85_pkg.sv
// Shared types, constants and helper functions for the base-85 stream decoder.
package a85_pkg;

    // Character codes and digit range.
    localparam logic [7:0] CH_SPACE      = 8'd32;
    localparam logic [7:0] DIGIT_LOW     = 8'd33;
    localparam logic [7:0] DIGIT_HIGH    = 8'd117;
    localparam logic [7:0] CH_ZERO_GROUP = 8'h7A;
    localparam logic [7:0] CH_END        = 8'h7E;
    localparam logic [7:0] CH_CLOSE      = 8'h3E;

    // Radix of one digit and the digits held before a group is complete.
    localparam logic [31:0] DIGIT_BASE = 32'd85;
    localparam logic [2:0]  LAST_DIGIT = 3'd4;
    localparam logic [2:0]  GROUP_LEN  = 3'd5;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Commands passed from the front to the back.
    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_ZERO,
        OP_END,
        OP_CLOSE,
        OP_BAD
    } a85_op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_END  = 2'd2
    } a85_status_t;

    // One queued command.
    typedef struct packed {
        a85_op_t    op;
        logic [6:0] digit;     // digit value 0..84
        logic       last;      // this digit completes the group
        logic [2:0] pad_len;   // number of pad digits appended at end of data
        logic [2:0] emit_cnt;  // bytes emitted at end of data
        logic       close_ok;  // closing character was '>'
    } a85_cmd_t;

    // 85 to the power k, modulo 2^32, for pad digit counts 1 to 4; any other count gives 1.
    function automatic logic [31:0] pad_power(input logic [2:0] k);
        logic [31:0] p;
        begin
            unique case (k)
                3'd1:    p = 32'd85;
                3'd2:    p = 32'd7225;
                3'd3:    p = 32'd614125;
                3'd4:    p = 32'd52200625;
                default: p = 32'd1;
            endcase
            return p;
        end
    endfunction

    // Mask that keeps the leading count bytes of a word.
    function automatic logic [31:0] keep_mask(input logic [2:0] count);
        logic [31:0] m;
        begin
            unique case (count)
                3'd0:    m = 32'h0000_0000;
                3'd1:    m = 32'hFF00_0000;
                3'd2:    m = 32'hFFFF_0000;
                3'd3:    m = 32'hFFFF_FF00;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

endpackage

// File: design/ascii85_stream_decoder.sv
// Top level of the base-85 stream decoder.
//
//  Channel  Handshake              Payload
//  input    in_valid / in_ready    char_in
//  config   cfg_we                 cfg_data (pad drop enable)
//  output   out_valid / out_ready  data_word, byte_count, is_end, status
//
// One character is taken per cycle while the queue has room. A result goes
// from its character's transfer through the command queue to the output
// register: the command enters the queue at the transfer edge and moves to
// the output register when that register is free or draining. The back end
// does one 32-bit constant multiply-add per command. Reset clears the group
// state, the queue and the output valid flag; no clearing pass is needed.
// An output stall fills the two-entry queue, after which in_ready drops.
module ascii85_stream_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_in,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        cfg_we,
    input  logic        cfg_data,
    output logic [31:0] data_word,
    output logic [2:0]  byte_count,
    output logic        is_end,
    output logic [1:0]  status,
    output logic        out_valid,
    input  logic        out_ready
);
    import a85_pkg::*;

    logic     push, queue_full, pop, queue_valid;
    a85_cmd_t push_cmd, head_cmd;

    // Character classification.
    a85_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue.
    a85_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_valid),
        .head_cmd  (head_cmd)
    );

    // Value accumulation and result register.
    a85_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_valid),
        .cmd        (head_cmd),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_word  (data_word),
        .byte_count (byte_count),
        .is_end     (is_end),
        .status     (status)
    );

endmodule

// File: design/a85_front.sv
// Front end: accepts characters, tracks group position and issues commands.
module a85_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        char_in,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              queue_full,
    output logic              push,
    output a85_pkg::a85_cmd_t push_cmd
);
    import a85_pkg::*;

    logic [2:0] digit_count_reg, digit_count_next;
    logic       awaiting_reg, awaiting_next;
    logic       drop_pad_reg;
    logic       accept;
    logic       skip;
    logic [7:0] digit_diff;
    logic [2:0] cnt_base;

    assign in_ready   = !queue_full;
    assign accept     = in_valid && in_ready;
    assign digit_diff = char_in - DIGIT_LOW;
    assign cnt_base   = (digit_count_reg == 3'd0) ? 3'd0 : digit_count_reg - 3'd1;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drop_pad_reg <= 1'b0;
        else if (cfg_we)
            drop_pad_reg <= cfg_data;
    end

    // Classify the character and build the command.
    always_comb
    begin
        digit_count_next  = digit_count_reg;
        awaiting_next     = awaiting_reg;
        skip              = 1'b0;
        push_cmd          = '0;
        push_cmd.op       = OP_BAD;
        push_cmd.digit    = digit_diff[6:0];
        push_cmd.last     = (digit_count_reg == LAST_DIGIT);
        push_cmd.pad_len  = GROUP_LEN - digit_count_reg;
        push_cmd.emit_cnt = (drop_pad_reg && cnt_base != 3'd0) ? cnt_base - 3'd1 : cnt_base;
        push_cmd.close_ok = (char_in == CH_CLOSE);
        priority if (awaiting_reg)
        begin
            push_cmd.op   = OP_CLOSE;
            awaiting_next = 1'b0;
        end
        else if (char_in <= CH_SPACE)
        begin
            skip = 1'b1;
        end
        else if (char_in == CH_END)
        begin
            push_cmd.op      = OP_END;
            digit_count_next = 3'd0;
            awaiting_next    = 1'b1;
        end
        else if (char_in == CH_ZERO_GROUP && digit_count_reg == 3'd0)
        begin
            push_cmd.op = OP_ZERO;
        end
        else if (char_in >= DIGIT_LOW && char_in <= DIGIT_HIGH)
        begin
            push_cmd.op      = OP_DIGIT;
            digit_count_next = (digit_count_reg == LAST_DIGIT) ? 3'd0 : digit_count_reg + 3'd1;
        end
        else
        begin
            push_cmd.op      = OP_BAD;
            digit_count_next = 3'd0;
        end
    end

    assign push = accept && !skip;

    // Group position and end-marker state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= 3'd0;
            awaiting_reg    <= 1'b0;
        end
        else if (accept)
        begin
            digit_count_reg <= digit_count_next;
            awaiting_reg    <= awaiting_next;
        end
    end

    // The group never holds five digits between transfers.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_count_reg <= LAST_DIGIT)
        else $error("front: digit count out of range");

    // An end marker always arms the closing check.
    a_end_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_cmd.op == OP_END) |=> (awaiting_reg && digit_count_reg == 3'd0))
        else $error("front: end marker did not arm closing check");

    // The character after an end marker always disarms the closing check.
    a_close_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && awaiting_reg) |=> !awaiting_reg)
        else $error("front: closing check still armed after its character");

endmodule

// File: design/a85_queue.sv
// Short command queue between the front end and the back end.
module a85_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  a85_pkg::a85_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output a85_pkg::a85_cmd_t head_cmd
);
    import a85_pkg::*;

    a85_cmd_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = mem_reg[rd_ptr_reg];

    // Pointer and fill-level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    // The front never offers a command while the queue is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue: push while full");

    // The fill level never exceeds the depth.
    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue: fill level out of range");

    // The back end never pops an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue: pop while empty");

endmodule

// File: design/a85_back.sv
// Back end: accumulates group values and registers the results.
module a85_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  a85_pkg::a85_cmd_t cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       data_word,
    output logic [2:0]        byte_count,
    output logic              is_end,
    output logic [1:0]        status
);
    import a85_pkg::*;

    logic [31:0]  group_reg, group_next;
    logic         out_valid_reg, out_valid_next;
    logic [31:0]  word_reg, word_next;
    logic [2:0]   count_reg, count_next;
    logic         end_reg, end_next;
    a85_status_t  status_reg, status_next;
    logic [31:0]  mul_k, add_val, pad_pow, acc;
    logic         emit;

    // A command is taken whenever the output register is free or draining.
    assign pop = cmd_valid && (!out_valid_reg || out_ready);

    // Shared multiply-add: one digit step, or all pad digits at once.
    assign pad_pow = pad_power(cmd.pad_len);
    always_comb
    begin
        if (cmd.op == OP_END)
        begin
            mul_k   = pad_pow;
            add_val = pad_pow - 32'd1;
        end
        else
        begin
            mul_k   = DIGIT_BASE;
            add_val = {25'd0, cmd.digit};
        end
    end
    assign acc = (group_reg * mul_k) + add_val;

    // Command execution.
    always_comb
    begin
        group_next  = group_reg;
        emit        = 1'b0;
        word_next   = 32'd0;
        count_next  = 3'd0;
        end_next    = 1'b0;
        status_next = ST_OK;
        unique case (cmd.op)
            OP_DIGIT:
            begin
                if (cmd.last)
                begin
                    emit       = 1'b1;
                    word_next  = acc;
                    count_next = FULL_BYTES;
                    group_next = 32'd0;
                end
                else
                begin
                    group_next = acc;
                end
            end
            OP_ZERO:
            begin
                emit       = 1'b1;
                count_next = FULL_BYTES;
            end
            OP_END:
            begin
                group_next = 32'd0;
                emit       = (cmd.emit_cnt != 3'd0);
                word_next  = acc & keep_mask(cmd.emit_cnt);
                count_next = cmd.emit_cnt;
            end
            OP_CLOSE:
            begin
                emit        = 1'b1;
                end_next    = 1'b1;
                status_next = cmd.close_ok ? ST_OK : ST_BAD_END;
            end
            default:
            begin
                group_next  = 32'd0;
                emit        = 1'b1;
                status_next = ST_BAD_CHAR;
            end
        endcase
    end

    always_comb
    begin
        if (pop)
            out_valid_next = emit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                group_reg <= group_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_reg   <= word_next;
            count_reg  <= count_next;
            end_reg    <= end_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_word  = word_reg;
    assign byte_count = count_reg;
    assign is_end     = end_reg;
    assign status     = status_reg;

    // End and error results carry no bytes.
    a_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (end_reg || status_reg != ST_OK)) |-> (count_reg == 3'd0))
        else $error("back: end or error result carries bytes");

    // A bad closing status only appears on an end result.
    a_bad_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_BAD_END) |-> end_reg)
        else $error("back: bad end status without end flag");

    // An end, close or bad command leaves the accumulator cleared.
    a_group_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cmd.op != OP_DIGIT && cmd.op != OP_ZERO) |=> (group_reg == 32'd0))
        else $error("back: group not cleared");

endmodule

// File: verif/ascii85_checker.sv
// Checker for the base-85 stream decoder: predicts every result and compares it.
`timescale 1ns / 1ps

module ascii85_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_in,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        is_end,
    input  logic [1:0]  status,
    input  logic        out_valid,
    input  logic        out_ready,
    output int          mismatch_count,
    output int          outstanding
);
    import a85_pkg::*;

    // One decoded result as the block should present it.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        at_end;
        a85_status_t st;
    } decoded_t;

    // Local copy of the decoder state and the pad drop setting.
    logic [31:0] group_val;
    logic [2:0]  digits;
    logic        wait_close;
    logic        drop_pad;

    // Results predicted but not yet seen on the output channel.
    decoded_t decoded_q[$];

    // Prints one line for a mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Advances the local decoder by one accepted character.
    task automatic decode_char(input logic [7:0] ch);
        decoded_t    r;
        logic [31:0] v;
        logic [2:0]  n;
        logic [2:0]  cnt;
        r.word   = '0;
        r.nbytes = '0;
        r.at_end = 1'b0;
        r.st     = ST_OK;
        if (wait_close)
        begin
            // The character after the end mark is checked even if it is whitespace.
            wait_close = 1'b0;
            r.at_end   = 1'b1;
            r.st       = (ch == CH_CLOSE) ? ST_OK : ST_BAD_END;
            decoded_q.push_back(r);
        end
        else if (ch <= CH_SPACE)
        begin
            // Whitespace is skipped.
        end
        else if (ch == CH_END)
        begin
            n          = digits;
            v          = group_val;
            group_val  = '0;
            digits     = '0;
            wait_close = 1'b1;
            if (n != 0)
            begin
                // Pad the partial group with the highest digit.
                for (int i = n; i < 5; i++)
                    v = v * DIGIT_BASE + 32'(DIGIT_HIGH - DIGIT_LOW);
                cnt = n - 3'd1;
                if (drop_pad && cnt != 0)
                    cnt = cnt - 3'd1;
                if (cnt != 0)
                begin
                    r.word   = v & ~(32'hFFFF_FFFF >> (cnt * 8));
                    r.nbytes = cnt;
                    decoded_q.push_back(r);
                end
            end
        end
        else if (ch == CH_ZERO_GROUP && digits == 0)
        begin
            r.nbytes = 3'd4;
            decoded_q.push_back(r);
        end
        else if (ch >= DIGIT_LOW && ch <= DIGIT_HIGH)
        begin
            group_val = group_val * DIGIT_BASE + 32'(ch - DIGIT_LOW);
            digits    = digits + 3'd1;
            if (digits == 3'd5)
            begin
                r.word    = group_val;
                r.nbytes  = 3'd4;
                group_val = '0;
                digits    = '0;
                decoded_q.push_back(r);
            end
        end
        else
        begin
            // Anything else is a bad character and drops the group.
            group_val = '0;
            digits    = '0;
            r.st      = ST_BAD_CHAR;
            decoded_q.push_back(r);
        end
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        decoded_t e;
        if (!rst_n)
        begin
            group_val  = '0;
            digits     = '0;
            wait_close = 1'b0;
            drop_pad   = 1'b0;
            decoded_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // Compare a result transfer with the oldest prediction.
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("result with none pending: word=%h count=%0d end=%0b status=%0d",
                                              data_word, byte_count, is_end, status));
                else
                begin
                    e = decoded_q.pop_front();
                    if (data_word !== e.word)
                        report_mismatch($sformatf("data_word %h, predicted %h", data_word, e.word));
                    if (byte_count !== e.nbytes)
                        report_mismatch($sformatf("byte_count %0d, predicted %0d",
                                                  byte_count, e.nbytes));
                    if (is_end !== e.at_end)
                        report_mismatch($sformatf("is_end %0b, predicted %0b", is_end, e.at_end));
                    if (status !== e.st)
                        report_mismatch($sformatf("status %0d, predicted %0d", status, e.st));
                end
            end

            if (cfg_we)
                drop_pad = cfg_data;

            // Predict from each character transfer.
            if (in_valid && in_ready)
                decode_char(char_in);

            outstanding <= decoded_q.size();
        end
    end

endmodule

// File: verif/ascii85_stream_decoder_tb.sv
// Testbench top for the base-85 stream decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module ascii85_stream_decoder_tb;

    import a85_pkg::*;

    localparam int     HALF_PERIOD   = 5;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     PHASE_CHARS   = 320;
    localparam int     SETTLE_CYCLES = 6;
    localparam longint TIMEOUT_NS    = 5_000_000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic [7:0]  char_in   = '0;
    logic        in_valid  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        is_end;
    logic [1:0]  status;
    logic        out_valid;

    int mismatch_count;
    int outstanding;

    // Idle and stall rates in percent, and the long hold-off request count.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int chars_sent    = 0;

    // Per-phase sender idling, receiver stalling and pad drop setting.
    int idle_by_phase[4]  = '{0, 51, 0, 24};
    int stall_by_phase[4] = '{0, 0, 51, 24};
    bit drop_by_phase[4]  = '{1'b0, 1'b1, 1'b0, 1'b1};

    always #HALF_PERIOD clk = ~clk;

    ascii85_stream_decoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .data_word  (data_word),
        .byte_count (byte_count),
        .is_end     (is_end),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    ascii85_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_in        (char_in),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .is_end         (is_end),
        .status         (status),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        int hold_seen;
        int hold_left;
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offers one character, with random idle cycles first, until it is transferred.
    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        char_in  <= ch;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Stops offering and waits until every predicted result has come out.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pad_drop(input bit v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Digit biased toward the ends of the range.
    function automatic logic [7:0] rand_digit();
        int r;
        r = $urandom_range(99);
        if (r < 15)
            return DIGIT_HIGH;
        else if (r < 25)
            return DIGIT_LOW;
        return 8'($urandom_range(DIGIT_HIGH, DIGIT_LOW));
    endfunction

    // One encoded stream: whole groups, a partial tail, the end mark and its close.
    // A small share carries noise, stray group-zero marks, bad closes or no end.
    task automatic send_stream();
        int groups;
        int tail;
        groups = $urandom_range(0, 5);
        for (int g = 0; g < groups; g++)
        begin
            if ($urandom_range(99) < 12)
                send_char(CH_ZERO_GROUP);
            else
                for (int d = 0; d < 5; d++)
                begin
                    if ($urandom_range(99) < 8)
                        send_char(8'($urandom_range(0, CH_SPACE)));
                    if ($urandom_range(99) < 2)
                        send_char(CH_ZERO_GROUP);
                    send_char(rand_digit());
                end
            if ($urandom_range(99) < 3)
                send_char(8'($urandom_range(0, 255)));
        end
        tail = $urandom_range(0, 4);
        for (int d = 0; d < tail; d++)
            send_char(rand_digit());
        if ($urandom_range(99) < 5)
            return;
        send_char(CH_END);
        if ($urandom_range(99) < 85)
            send_char(CH_CLOSE);
        else
            send_char(8'($urandom_range(0, 255)));
    endtask

    // Stimulus and verdict.
    initial
    begin
        int phase_end;
        int stream_no;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_pad_drop(1'b0);

        // Directed part: lowest and highest full groups, the wrapping group,
        // the group-zero mark at group start and inside a group, whitespace
        // edges, bytes just outside the digit range, partial ends, an empty
        // end, whitespace after the end mark and a second end mark as close.
        send_text("!!!!!");
        send_text("uuuuu");
        send_char(CH_ZERO_GROUP);
        send_char(8'h00);
        send_char(CH_SPACE);
        send_text("!z");
        send_char(8'hFF);
        send_char(DIGIT_HIGH + 8'd1);
        send_text("s8~>");
        send_text("~ ");
        send_text("uuuu~~");

        // Random phases with different idling and pad drop settings.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_pad_drop(drop_by_phase[ph]);
            send_idle_pct = idle_by_phase[ph];
            stall_pct    <= stall_by_phase[ph];
            phase_end     = chars_sent + PHASE_CHARS;
            stream_no     = 0;
            while (chars_sent < phase_end)
            begin
                // Long receiver hold-off while characters keep coming.
                if (ph == 0 && stream_no == 2)
                    hold_req <= hold_req + 1;
                // Sender pause until the output has caught up.
                if (stream_no == 12)
                    wait_drained();
                send_stream();
                stream_no++;
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("ascii85_stream_decoder_tb passed");
        else
            $display("ascii85_stream_decoder_tb failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_NS);
        $display("ascii85_stream_decoder_tb failed");
        $finish;
    end

endmodule
